/* design/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, register codes and transfer types of the timed trigger
// sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int SAMPLE_RATE_W = 18;
    localparam int DELAY_W       = 31;
    localparam int COUNT_W       = 5;
    localparam int TIME_W        = 32;
    localparam int INDEX_W       = 4;
    localparam int DURATION_W    = 31;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 31;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 32;

    localparam int PROD_W      = TIME_W + SAMPLE_RATE_W;
    localparam int INIT_PROD_W = DELAY_W + SAMPLE_RATE_W;

    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_FRACTION_BITS = 24;

    localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RST = SAMPLE_RATE_W'(48000);
    localparam logic [DELAY_W-1:0]       DELAY_RST       = '0;
    localparam logic [COUNT_W-1:0]       COUNT_RST       = COUNT_W'(1);

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_RATE   = 2'd0,
        REG_INITIAL_DELAY = 2'd1,
        REG_ENTRY_COUNT   = 2'd2,
        REG_LOOP_ENABLE   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_RATE_W-1:0] sample_rate;
        logic [COUNT_W-1:0]       entry_count;
        logic                     loop_enable;
        logic [INIT_PROD_W-1:0]   init_prod;
    } cfg_t;

    typedef struct packed {
        logic                func;
        logic                restart;
        logic [INDEX_W-1:0]  entry_index;
        logic [TIME_W-1:0]   entry_time;
    } item_t;

    typedef struct packed {
        logic                  trigger;
        logic [DURATION_W-1:0] duration;
        logic                  end_of_sequence;
    } result_t;

endpackage

/* design/tts_config.sv */
// ----------------------------------------------------------------------------
// tts_config
// Configuration registers, with the initial delay tick product kept up to
// date on each write of the sample rate or initial delay.
// ----------------------------------------------------------------------------
module tts_config (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tts_pkg::cfg_t                  cfg
);
    import tts_pkg::*;

    logic [SAMPLE_RATE_W-1:0] rate_reg, rate_next;
    logic [DELAY_W-1:0]       delay_reg, delay_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     loop_reg, loop_next;
    logic [INIT_PROD_W-1:0]   prod_reg, prod_next;
    logic [DELAY_W-1:0]       op_delay;
    logic [SAMPLE_RATE_W-1:0] op_rate;
    cfg_reg_t                 sel;

    assign sel = cfg_reg_t'(cfg_index);

    assign op_delay = (sel == REG_INITIAL_DELAY) ? cfg_data[DELAY_W-1:0] : delay_reg;
    assign op_rate  = (sel == REG_SAMPLE_RATE) ? cfg_data[SAMPLE_RATE_W-1:0] : rate_reg;

    always_comb begin
        rate_next  = rate_reg;
        delay_next = delay_reg;
        count_next = count_reg;
        loop_next  = loop_reg;
        prod_next  = prod_reg;
        if (cfg_valid) begin
            unique case (sel)
                REG_SAMPLE_RATE: begin
                    rate_next = cfg_data[SAMPLE_RATE_W-1:0];
                    prod_next = INIT_PROD_W'(op_delay) * INIT_PROD_W'(op_rate);
                end
                REG_INITIAL_DELAY: begin
                    delay_next = cfg_data[DELAY_W-1:0];
                    prod_next  = INIT_PROD_W'(op_delay) * INIT_PROD_W'(op_rate);
                end
                REG_ENTRY_COUNT: begin
                    count_next = cfg_data[COUNT_W-1:0];
                end
                REG_LOOP_ENABLE: begin
                    loop_next = cfg_data[0];
                end
                default: begin
                    rate_next = rate_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= SAMPLE_RATE_RST;
            delay_reg <= DELAY_RST;
            count_reg <= COUNT_RST;
            loop_reg  <= 1'b0;
            prod_reg  <= '0;
        end else begin
            rate_reg  <= rate_next;
            delay_reg <= delay_next;
            count_reg <= count_next;
            loop_reg  <= loop_next;
            prod_reg  <= prod_next;
        end
    end

    assign cfg.sample_rate = rate_reg;
    assign cfg.entry_count = count_reg;
    assign cfg.loop_enable = loop_reg;
    assign cfg.init_prod   = prod_reg;

endmodule

/* design/tts_table.sv */
// ----------------------------------------------------------------------------
// tts_table
// Step time table: one write port, one read port.
// ----------------------------------------------------------------------------
module tts_table #(
    parameter int TABLE_DEPTH = tts_pkg::DEF_TABLE_DEPTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [tts_pkg::INDEX_W-1:0] wr_index,
    input  logic [tts_pkg::TIME_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]            rd_index,
    output logic [tts_pkg::TIME_W-1:0]  rd_data
);
    import tts_pkg::*;

    localparam int AW = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    logic [TIME_W-1:0] entry_mem [TABLE_DEPTH];
    logic [AW-1:0]     wr_ext;
    logic              wr_in_range;

    assign wr_ext      = AW'(wr_index);
    assign wr_in_range = (32'(wr_index) < TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            entry_mem[wr_ext[IDX_W-1:0]] <= wr_data;
        end
    end

    assign rd_data = entry_mem[rd_index];

endmodule

/* design/tts_core.sv */
// ----------------------------------------------------------------------------
// tts_core
// Sequencer state and the per-tick step: countdown, entry take, reload
// with fractional carry, end of sequence and wrap.
// ----------------------------------------------------------------------------
module tts_core #(
    parameter int TABLE_DEPTH   = tts_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = tts_pkg::DEF_FRACTION_BITS,
    parameter int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tick_fire,
    input  logic                       restart,
    input  tts_pkg::cfg_t              cfg,
    output logic [IDX_W-1:0]           rd_index,
    input  logic [tts_pkg::TIME_W-1:0] rd_data,
    output tts_pkg::result_t           result
);
    import tts_pkg::*;

    localparam int INT_W  = PROD_W - FRACTION_BITS;
    localparam int CNT_W  = INT_W + 2;
    localparam int POS_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ACW    = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    logic [CNT_W-1:0]         cnt_reg, cnt_next, cnt_base, cnt_reload;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next, frac_base;
    logic [POS_W-1:0]         pos_reg, pos_next, pos_base, pos_inc;
    logic [ACW-1:0]           count_ext, active;
    logic                     running, take, last, positive;
    logic [TIME_W-1:0]        mag;
    logic [PROD_W-1:0]        prod;
    logic [FRACTION_BITS:0]   frac_sum;

    assign cnt_base  = restart ? CNT_W'(cfg.init_prod[INIT_PROD_W-1:FRACTION_BITS]) : cnt_reg;
    assign frac_base = restart ? cfg.init_prod[FRACTION_BITS-1:0] : frac_reg;
    assign pos_base  = restart ? '0 : pos_reg;

    assign count_ext = ACW'(cfg.entry_count);
    assign active    = (count_ext > ACW'(TABLE_DEPTH)) ? ACW'(TABLE_DEPTH) : count_ext;
    assign running   = (ACW'(pos_base) < active);
    assign take      = running && (cnt_base[CNT_W-1] || (cnt_base == '0));
    assign pos_inc   = pos_base + POS_W'(1);
    assign last      = (ACW'(pos_inc) == active);

    assign rd_index  = pos_base[IDX_W-1:0];
    assign positive  = !rd_data[TIME_W-1] && (rd_data != '0);
    assign mag       = rd_data[TIME_W-1] ? (~rd_data + TIME_W'(1)) : rd_data;
    assign prod      = PROD_W'(mag) * PROD_W'(cfg.sample_rate);
    assign frac_sum  = {1'b0, frac_base} + {1'b0, prod[FRACTION_BITS-1:0]};
    assign cnt_reload = CNT_W'(prod[PROD_W-1:FRACTION_BITS])
                      + CNT_W'(frac_sum[FRACTION_BITS]);

    always_comb begin
        cnt_next  = cnt_base;
        frac_next = frac_base;
        pos_next  = pos_base;
        if (running) begin
            if (take) begin
                cnt_next  = cnt_reload - CNT_W'(1);
                frac_next = frac_sum[FRACTION_BITS-1:0];
                pos_next  = (last && cfg.loop_enable) ? '0 : pos_inc;
            end else begin
                cnt_next = cnt_base - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            frac_reg <= '0;
            pos_reg  <= '0;
        end else if (tick_fire) begin
            cnt_reg  <= cnt_next;
            frac_reg <= frac_next;
            pos_reg  <= pos_next;
        end
    end

    assign result.trigger         = take && positive;
    assign result.duration        = (take && positive) ? rd_data[DURATION_W-1:0] : '0;
    assign result.end_of_sequence = take && last;

endmodule

/* design/timed_trigger_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_trigger_sequencer
// Sample-tick trigger sequencer over a table of signed Q8.24 step times.
// ----------------------------------------------------------------------------
// The s_ channel carries one item per transfer. tuser selects the kind:
// 0 is one sample tick (restart in tdata bit 0), 1 writes a table entry
// (entry_index and entry_time). Each tick gives one m_ transfer carrying
// trigger and duration in tdata, with end_of_sequence on tlast; a table
// write gives no result.
// The cfg_ channel writes the four registers (sample rate, initial delay,
// entry count, loop enable) and is always ready; a write to the sample
// rate or initial delay also updates the initial tick product.
// An accepted item is held in the input register; a tick's result is
// loaded into the output register as the tick leaves the input register,
// which raises m_tvalid. One item per cycle is sustained while the output
// is not stalled: the countdown, table read, one 32 x 18 multiply and the
// fraction carry all sit between the input and output registers.
// Reset clears the sequence to step 0 with the register reset values and
// empties both registers; table contents are undefined until written.
// When m_tready is low the output register holds its result, a pending
// tick holds in the input register and s_tready drops; table writes still
// drain.
// ----------------------------------------------------------------------------
module timed_trigger_sequencer #(
    parameter int TABLE_DEPTH   = tts_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = tts_pkg::DEF_FRACTION_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // restart [0], entry_index [4:1], entry_time [36:5], zero fill [39:37]
    input  logic [tts_pkg::S_TDATA_W-1:0]    s_tdata,
    // func [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // trigger [0], duration [31:1]
    output logic [tts_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tts_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    item_t             item_reg, item_next;
    logic              in_valid_reg, in_valid_next;
    result_t           result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_is_write, out_free, advance, tick_fire;
    cfg_t              cfg;
    logic [IDX_W-1:0]  rd_index;
    logic [TIME_W-1:0] rd_data;

    assign item_next.func        = s_tuser;
    assign item_next.restart     = s_tdata[0];
    assign item_next.entry_index = s_tdata[INDEX_W:1];
    assign item_next.entry_time  = s_tdata[INDEX_W+TIME_W:INDEX_W+1];

    assign in_is_write = (item_reg.func == FUNC_WRITE);
    assign out_free    = !out_valid_reg || m_tready;
    assign advance     = in_valid_reg && (in_is_write || out_free);
    assign tick_fire   = advance && !in_is_write;
    assign s_tready    = !in_valid_reg || advance;
    assign cfg_ready   = 1'b1;

    assign in_valid_next  = s_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = tick_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    tts_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tts_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (advance && in_is_write),
        .wr_index (item_reg.entry_index),
        .wr_data  (item_reg.entry_time),
        .rd_index (rd_index),
        .rd_data  (rd_data)
    );

    tts_core #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS),
        .IDX_W         (IDX_W)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_fire (tick_fire),
        .restart   (item_reg.restart),
        .cfg       (cfg),
        .rd_index  (rd_index),
        .rd_data   (rd_data),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
        if (tick_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.duration, result_reg.trigger};
    assign m_tlast  = result_reg.end_of_sequence;

    // a new result only follows a tick leaving the input register
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(tick_fire))
        else $error("result without a tick");

    // a tick blocked by a stalled output stays pending
    a_tick_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_is_write && !out_free) |=> in_valid_reg)
        else $error("pending tick lost under stall");

    // a trigger always reports a non-zero duration
    a_trigger_duration: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.trigger) |-> (result_reg.duration != '0))
        else $error("trigger with zero duration");

    // duration is zero without a trigger
    a_no_trigger_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.trigger) |-> (result_reg.duration == '0))
        else $error("duration without trigger");

endmodule
